>>> rtl/core/kcsl_pkg.sv
// shared types, codes and arithmetic helpers of the spiking layer
package kcsl_pkg;

	localparam logic [2:0] OP_SET_RATE   = 3'd0;
	localparam logic [2:0] OP_STEP       = 3'd1;
	localparam logic [2:0] OP_RESET      = 3'd2;
	localparam logic [2:0] OP_READ       = 3'd3;
	localparam logic [2:0] OP_LOAD_CLAW  = 3'd4;
	localparam logic [2:0] OP_LOAD_THR   = 3'd5;

	localparam logic [2:0] REG_MEMBRANE_RATE   = 3'd0;
	localparam logic [2:0] REG_INHIBITION_RATE = 3'd1;
	localparam logic [2:0] REG_DRIVE_RATE      = 3'd2;
	localparam logic [2:0] REG_GAIN            = 3'd3;
	localparam logic [2:0] REG_INH_WEIGHT      = 3'd4;
	localparam logic [2:0] REG_ACTIVE_NEURONS  = 3'd5;
	localparam logic [2:0] REG_ACTIVE_INPUTS   = 3'd6;

	localparam logic [16:0] RST_MEMBRANE_RATE   = 17'd3277;
	localparam logic [16:0] RST_INHIBITION_RATE = 17'd655;
	localparam logic [16:0] RST_DRIVE_RATE      = 17'd3277;
	localparam logic [30:0] RST_GAIN            = 31'd327680;
	localparam logic [30:0] RST_INH_WEIGHT      = 31'd0;
	localparam logic [11:0] RST_ACTIVE_NEURONS  = 12'd2000;
	localparam logic [6:0]  RST_ACTIVE_INPUTS   = 7'd23;

	typedef struct packed {
		logic [2:0]         op;
		logic [10:0]        ni;
		logic [5:0]         ii;
		logic signed [31:0] value;
		logic [3:0]         claws;
		logic               n_ok;
		logic               i_ok;
	} cmd_t;

	typedef struct packed {
		logic [16:0] membrane_rate;
		logic [16:0] inhibition_rate;
		logic [16:0] drive_rate;
		logic [30:0] gain;
		logic [30:0] weight;
	} cfg_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sd2147483647;
		lo = -64'sd2147483648;
		if (x > hi)
			return 32'sh7fffffff;
		else if (x < lo)
			return 32'sh80000000;
		else
			return x[31:0];
	endfunction

endpackage

>>> rtl/core/kc_spiking_layer.sv
// top level of the spiking layer: register port, front end and back end
// Commands enter on start/busy: a transaction happens at a clock edge with start high
// and busy low. Loads, reads and steps queue in a two-entry command queue, so the
// front can take a new transaction while the back end is still working.
// Each command gives exactly one result, shown for one cycle with done high; the
// receiver cannot stall, so results are never held back.
// A step's run time is set by the per-neuron accumulate loop over one claw-weight memory port.
// Reset and trial reset clear membrane and spike-count memories in a pass over all
// MAX_NEURONS entries, one entry a cycle; after reset busy stays high during it.
// Rates, claw weights and thresholds are undefined until loaded.
// The user must write registers over the APB port only while the block is idle; the block itself does not enforce it.
module kc_spiking_layer #(
	parameter int MAX_NEURONS = 2048,
	parameter int MAX_INPUTS  = 64,
	parameter int FRAC_BITS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         op,
	input  logic [10:0]        neuron_index,
	input  logic [5:0]         input_index,
	input  logic signed [31:0] value,
	input  logic [3:0]         claw_count,
	output logic               done,
	output logic [11:0]        step_spikes,
	output logic [15:0]        neuron_spike_count,
	output logic               neuron_responded
);

	localparam int NA = $clog2(MAX_NEURONS);
	localparam int IA = $clog2(MAX_INPUTS);

	kcsl_pkg::cfg_t cfg_q;
	logic [11:0]    act_n_q;
	logic [6:0]     act_i_q;
	logic [NA:0]    nn;
	logic [IA:0]    ni;
	logic           wr_en;
	kcsl_pkg::cmd_t head;
	logic           head_valid;
	logic           pop;
	logic           hold;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign nn     = (32'(act_n_q) > MAX_NEURONS) ? (NA+1)'(MAX_NEURONS) : (NA+1)'(act_n_q);
	assign ni     = (32'(act_i_q) > MAX_INPUTS) ? (IA+1)'(MAX_INPUTS) : (IA+1)'(act_i_q);

	always_comb begin
		case (paddr[4:2])
			kcsl_pkg::REG_MEMBRANE_RATE:   prdata = 32'(cfg_q.membrane_rate);
			kcsl_pkg::REG_INHIBITION_RATE: prdata = 32'(cfg_q.inhibition_rate);
			kcsl_pkg::REG_DRIVE_RATE:      prdata = 32'(cfg_q.drive_rate);
			kcsl_pkg::REG_GAIN:            prdata = 32'(cfg_q.gain);
			kcsl_pkg::REG_INH_WEIGHT:      prdata = 32'(cfg_q.weight);
			kcsl_pkg::REG_ACTIVE_NEURONS:  prdata = 32'(act_n_q);
			kcsl_pkg::REG_ACTIVE_INPUTS:   prdata = 32'(act_i_q);
			default:                       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.membrane_rate   <= kcsl_pkg::RST_MEMBRANE_RATE;
			cfg_q.inhibition_rate <= kcsl_pkg::RST_INHIBITION_RATE;
			cfg_q.drive_rate      <= kcsl_pkg::RST_DRIVE_RATE;
			cfg_q.gain            <= kcsl_pkg::RST_GAIN;
			cfg_q.weight          <= kcsl_pkg::RST_INH_WEIGHT;
			act_n_q               <= kcsl_pkg::RST_ACTIVE_NEURONS;
			act_i_q               <= kcsl_pkg::RST_ACTIVE_INPUTS;
		end else if (wr_en) begin
			case (paddr[4:2])
				kcsl_pkg::REG_MEMBRANE_RATE:   cfg_q.membrane_rate   <= pwdata[16:0];
				kcsl_pkg::REG_INHIBITION_RATE: cfg_q.inhibition_rate <= pwdata[16:0];
				kcsl_pkg::REG_DRIVE_RATE:      cfg_q.drive_rate      <= pwdata[16:0];
				kcsl_pkg::REG_GAIN:            cfg_q.gain            <= pwdata[30:0];
				kcsl_pkg::REG_INH_WEIGHT:      cfg_q.weight          <= pwdata[30:0];
				kcsl_pkg::REG_ACTIVE_NEURONS:  act_n_q               <= pwdata[11:0];
				kcsl_pkg::REG_ACTIVE_INPUTS:   act_i_q               <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	kcsl_front #(
		.MAX_NEURONS (MAX_NEURONS),
		.MAX_INPUTS  (MAX_INPUTS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.neuron_index (neuron_index),
		.input_index  (input_index),
		.value        (value),
		.claw_count   (claw_count),
		.hold         (hold),
		.pop          (pop),
		.head         (head),
		.head_valid   (head_valid)
	);

	kcsl_back #(
		.MAX_NEURONS (MAX_NEURONS),
		.MAX_INPUTS  (MAX_INPUTS),
		.FRAC_BITS   (FRAC_BITS)
	) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg_q),
		.nn                 (nn),
		.ni                 (ni),
		.head               (head),
		.head_valid         (head_valid),
		.pop                (pop),
		.hold               (hold),
		.done               (done),
		.step_spikes        (step_spikes),
		.neuron_spike_count (neuron_spike_count),
		.neuron_responded   (neuron_responded)
	);

endmodule

>>> rtl/core/kcsl_front.sv
// front end: takes commands, checks index ranges and queues them
module kcsl_front #(
	parameter int MAX_NEURONS = 2048,
	parameter int MAX_INPUTS  = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [2:0]           op,
	input  logic [10:0]          neuron_index,
	input  logic [5:0]           input_index,
	input  logic signed [31:0]   value,
	input  logic [3:0]           claw_count,
	input  logic                 hold,
	input  logic                 pop,
	output kcsl_pkg::cmd_t       head,
	output logic                 head_valid
);

	kcsl_pkg::cmd_t ent_q [2];
	kcsl_pkg::cmd_t cmd_in;
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	logic           push;

	always_comb begin
		cmd_in.op    = op;
		cmd_in.ni    = neuron_index;
		cmd_in.ii    = input_index;
		cmd_in.value = value;
		cmd_in.claws = claw_count;
		cmd_in.n_ok  = 32'(neuron_index) < MAX_NEURONS;
		cmd_in.i_ok  = 32'(input_index) < MAX_INPUTS;
	end

	assign busy       = (cnt_q == 2'd2) || hold;
	assign push       = start && !busy;
	assign head       = ent_q[rd_q];
	assign head_valid = cnt_q != 2'd0;

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= cmd_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

>>> rtl/core/kcsl_back.sv
// back end: stores, inhibition update and per-neuron integrate-and-fire sequencer
module kcsl_back #(
	parameter int MAX_NEURONS = 2048,
	parameter int MAX_INPUTS  = 64,
	parameter int FRAC_BITS   = 16,
	localparam int NA = $clog2(MAX_NEURONS),
	localparam int IA = $clog2(MAX_INPUTS),
	localparam int ACC_W = 32 + 4 + IA + 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  kcsl_pkg::cfg_t cfg,
	input  logic [NA:0]    nn,
	input  logic [IA:0]    ni,
	input  kcsl_pkg::cmd_t head,
	input  logic           head_valid,
	output logic           pop,
	output logic           hold,
	output logic           done,
	output logic [11:0]    step_spikes,
	output logic [15:0]    neuron_spike_count,
	output logic           neuron_responded
);

	typedef enum logic [11:0] {
		ST_CLR   = 12'b000000000001,
		ST_IDLE  = 12'b000000000010,
		ST_RD    = 12'b000000000100,
		ST_INH1  = 12'b000000001000,
		ST_INH2  = 12'b000000010000,
		ST_INH3  = 12'b000000100000,
		ST_INH4  = 12'b000001000000,
		ST_NACC  = 12'b000010000000,
		ST_NLAST = 12'b000100000000,
		ST_NDIFF = 12'b001000000000,
		ST_NMUL  = 12'b010000000000,
		ST_NUPD  = 12'b100000000000
	} state_t;

	state_t state_q;

	logic signed [31:0] rate_mem [MAX_INPUTS];
	logic [3:0]         claw_mem [MAX_NEURONS * MAX_INPUTS];
	logic signed [31:0] thr_mem  [MAX_NEURONS];
	logic signed [31:0] vm_mem   [MAX_NEURONS];
	logic [15:0]        cnt_mem  [MAX_NEURONS];

	logic signed [31:0] rate_rd_q, thr_rd_q, vm_rd_q;
	logic [3:0]         claw_rd_q;
	logic [15:0]        cnt_rd_q;

	logic [NA-1:0]      n_q;
	logic [IA-1:0]      j_q;
	logic [NA-1:0]      clr_q;
	logic               clr_emit_q;
	logic [NA:0]        fired_q;
	logic               rd_vld_q;
	logic signed [ACC_W-1:0] acc_q;

	logic signed [31:0] drive_q, level_q, inh_q;
	logic [11:0]        prev_q;
	logic [42:0]        p_tgt_s1;
	logic signed [49:0] p_lvl_s1;
	logic signed [63:0] p_inh_s1;
	logic signed [32:0] dd_s2;
	logic signed [49:0] p_drv_s3;
	logic signed [33:0] d_s1;
	logic signed [51:0] p_mem_s2;

	logic               is_idle_pop;
	logic [NA-1:0]      cnt_addr;
	logic [NA-1:0]      hn;
	logic [IA-1:0]      hi;
	logic signed [31:0] v_new;
	logic               fire;
	logic [15:0]        cnt_inc;
	logic [NA:0]        fired_nx;
	logic               last_n;
	logic               last_j;
	logic               vm_we, cnt_we;
	logic [NA-1:0]      wr_addr;
	logic signed [31:0] vm_wd;
	logic [15:0]        cnt_wd;

	assign hn          = NA'(head.ni);
	assign hi          = IA'(head.ii);
	assign is_idle_pop = (state_q == ST_IDLE) && head_valid;
	assign pop         = is_idle_pop;
	assign hold        = (state_q == ST_CLR) && !clr_emit_q;
	assign cnt_addr    = (state_q == ST_IDLE) ? hn : n_q;
	assign last_n      = ((NA+1)'(n_q) + (NA+1)'(1)) == nn;
	assign last_j      = ((IA+1)'(j_q) + (IA+1)'(1)) == ni;

	always_comb begin
		v_new    = kcsl_pkg::sat32(64'(vm_rd_q) + 64'(p_mem_s2 >>> FRAC_BITS));
		fire     = v_new > thr_rd_q;
		cnt_inc  = (cnt_rd_q == 16'hffff) ? cnt_rd_q : cnt_rd_q + 16'd1;
		fired_nx = fired_q + (NA+1)'(fire);
		vm_we    = (state_q == ST_CLR) || (state_q == ST_NUPD);
		cnt_we   = (state_q == ST_CLR) || ((state_q == ST_NUPD) && fire);
		wr_addr  = (state_q == ST_CLR) ? clr_q : n_q;
		vm_wd    = ((state_q == ST_CLR) || fire) ? 32'sd0 : v_new;
		cnt_wd   = (state_q == ST_CLR) ? 16'd0 : cnt_inc;
	end

	// memories
	always_ff @(posedge clk) begin
		if (is_idle_pop && head.op == kcsl_pkg::OP_SET_RATE && head.i_ok)
			rate_mem[hi] <= head.value;
		rate_rd_q <= rate_mem[j_q];
	end

	always_ff @(posedge clk) begin
		if (is_idle_pop && head.op == kcsl_pkg::OP_LOAD_CLAW && head.n_ok && head.i_ok)
			claw_mem[{hn, hi}] <= head.claws;
		claw_rd_q <= claw_mem[{n_q, j_q}];
	end

	always_ff @(posedge clk) begin
		if (is_idle_pop && head.op == kcsl_pkg::OP_LOAD_THR && head.n_ok)
			thr_mem[hn] <= head.value;
		thr_rd_q <= thr_mem[n_q];
	end

	always_ff @(posedge clk) begin
		if (vm_we)
			vm_mem[wr_addr] <= vm_wd;
		vm_rd_q <= vm_mem[n_q];
	end

	always_ff @(posedge clk) begin
		if (cnt_we)
			cnt_mem[wr_addr] <= cnt_wd;
		cnt_rd_q <= cnt_mem[cnt_addr];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		p_tgt_s1 <= 43'(cfg.gain) * 43'(prev_q);
		p_lvl_s1 <= 50'(33'(drive_q) - 33'(level_q)) * 50'($signed({1'b0, cfg.inhibition_rate}));
		p_inh_s1 <= 64'($signed({1'b0, cfg.weight})) * 64'(level_q);
		dd_s2    <= 33'(kcsl_pkg::sat32($signed(64'(p_tgt_s1)))) - 33'(drive_q);
		p_drv_s3 <= 50'(dd_s2) * 50'($signed({1'b0, cfg.drive_rate}));
		d_s1     <= 34'(kcsl_pkg::sat32(64'(acc_q))) - 34'(inh_q) - 34'(vm_rd_q);
		p_mem_s2 <= 52'(d_s1) * 52'($signed({1'b0, cfg.membrane_rate}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= ST_CLR;
			clr_q              <= '0;
			clr_emit_q         <= 1'b0;
			n_q                <= '0;
			j_q                <= '0;
			fired_q            <= '0;
			rd_vld_q           <= 1'b0;
			acc_q              <= '0;
			drive_q            <= '0;
			level_q            <= '0;
			inh_q              <= '0;
			prev_q             <= '0;
			done               <= 1'b0;
			step_spikes        <= '0;
			neuron_spike_count <= '0;
			neuron_responded   <= 1'b0;
		end else begin
			done               <= 1'b0;
			step_spikes        <= '0;
			neuron_spike_count <= '0;
			neuron_responded   <= 1'b0;
			rd_vld_q           <= (state_q == ST_NACC);
			if (rd_vld_q)
				acc_q <= acc_q + ACC_W'($signed({1'b0, claw_rd_q})) * ACC_W'(rate_rd_q);
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + NA'(1);
					if (32'(clr_q) == MAX_NEURONS - 1) begin
						clr_q      <= '0;
						done       <= clr_emit_q;
						clr_emit_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (head_valid) begin
						case (head.op)
							kcsl_pkg::OP_STEP: state_q <= ST_INH1;
							kcsl_pkg::OP_RESET: begin
								drive_q    <= '0;
								level_q    <= '0;
								prev_q     <= '0;
								clr_emit_q <= 1'b1;
								state_q    <= ST_CLR;
							end
							kcsl_pkg::OP_READ: begin
								if (head.n_ok)
									state_q <= ST_RD;
								else
									done <= 1'b1;
							end
							default: done <= 1'b1;
						endcase
					end
				end
				ST_RD: begin
					done               <= 1'b1;
					neuron_spike_count <= cnt_rd_q;
					neuron_responded   <= cnt_rd_q != 16'd0;
					state_q            <= ST_IDLE;
				end
				ST_INH1: state_q <= ST_INH2;
				ST_INH2: state_q <= ST_INH3;
				ST_INH3: state_q <= ST_INH4;
				ST_INH4: begin
					drive_q <= kcsl_pkg::sat32(64'(drive_q) + 64'(p_drv_s3 >>> FRAC_BITS));
					level_q <= kcsl_pkg::sat32(64'(level_q) + 64'(p_lvl_s1 >>> FRAC_BITS));
					inh_q   <= kcsl_pkg::sat32(p_inh_s1 >>> FRAC_BITS);
					n_q     <= '0;
					j_q     <= '0;
					fired_q <= '0;
					acc_q   <= '0;
					if (nn == '0) begin
						done    <= 1'b1;
						prev_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						state_q <= (ni == '0) ? ST_NLAST : ST_NACC;
					end
				end
				ST_NACC: begin
					j_q <= j_q + IA'(1);
					if (last_j)
						state_q <= ST_NLAST;
				end
				ST_NLAST: state_q <= ST_NDIFF;
				ST_NDIFF: state_q <= ST_NMUL;
				ST_NMUL:  state_q <= ST_NUPD;
				ST_NUPD: begin
					fired_q <= fired_nx;
					j_q     <= '0;
					acc_q   <= '0;
					if (last_n) begin
						done        <= 1'b1;
						step_spikes <= 12'(fired_nx);
						prev_q      <= 12'(fired_nx);
						state_q     <= ST_IDLE;
					end else begin
						n_q     <= n_q + NA'(1);
						state_q <= (ni == '0) ? ST_NLAST : ST_NACC;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/kcsl_checker.sv
// port-level checks of the spiking layer and their binding
module kcsl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pready,
	input logic        done,
	input logic [11:0] step_spikes,
	input logic [15:0] neuron_spike_count,
	input logic        neuron_responded
);

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> (step_spikes == 12'd0 && neuron_spike_count == 16'd0 && !neuron_responded))
		else $error("result fields not zero outside a result cycle");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (step_spikes == 12'd0 || neuron_spike_count == 16'd0))
		else $error("step and read results mixed");

	a_responded: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (neuron_responded == (neuron_spike_count != 16'd0)))
		else $error("responded flag disagrees with spike count");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind kc_spiking_layer kcsl_checker u_kcsl_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.pready             (pready),
	.done               (done),
	.step_spikes        (step_spikes),
	.neuron_spike_count (neuron_spike_count),
	.neuron_responded   (neuron_responded)
);
